// File: src/fpss_pkg.sv
package fpss_pkg;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 32;
    localparam int TEXT_MAX_DEF    = 4096;

    // Fixed field widths
    localparam int PLEN_W  = 6;
    localparam int PIDX_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int START_W = 12;
    localparam int END_W   = 13;

    // Register indexes on the APB port (byte address 4*i)
    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_DIRECTION      = 1'b1;

    // Request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TEXT = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [PIDX_W-1:0] pattern_index;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] match_start;
        logic [END_W-1:0]   match_end;
        logic               overflow;
    } t_res;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] data;
    } t_cell_ctl;

endpackage

// File: src/fpss_cell.sv
module fpss_cell (
    input  logic                      i_clk,
    input  fpss_pkg::t_cell_ctl       i_ctl,
    input  logic                      i_load,
    input  logic [fpss_pkg::BYTE_W-1:0] i_shift_byte,
    input  logic [fpss_pkg::BYTE_W-1:0] i_align_pat,
    input  logic                      i_care,
    output logic [fpss_pkg::BYTE_W-1:0] o_win,
    output logic [fpss_pkg::BYTE_W-1:0] o_pat,
    output logic                      o_hit
);
    import fpss_pkg::*;

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_pat;

    // window byte moves one place toward the oldest end per text byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= i_shift_byte;
        end
        if (i_load) begin
            r_pat <= i_ctl.data;
        end
    end

    // compare against the value the window takes on this shift
    assign o_hit = !i_care || (i_shift_byte == i_align_pat);
    assign o_win = r_win;
    assign o_pat = r_pat;

endmodule

// File: src/fpss_align.sv
module fpss_align #(
    parameter int PATTERN_MAX = fpss_pkg::PATTERN_MAX_DEF
) (
    input  logic [PATTERN_MAX-1:0][fpss_pkg::BYTE_W-1:0] i_pat,
    input  logic [fpss_pkg::PLEN_W-1:0]                  i_plen,
    output logic [PATTERN_MAX-1:0][fpss_pkg::BYTE_W-1:0] o_align,
    output logic [PATTERN_MAX-1:0]                       o_care,
    output logic                                         o_plen_ok
);
    import fpss_pkg::*;

    localparam int SHW = $clog2(PATTERN_MAX);

    logic [SHW-1:0] base;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] stg [SHW+1];

    assign o_plen_ok = (i_plen != '0) && (int'(i_plen) <= PATTERN_MAX);

    // pattern byte k lines up with window slot base+k
    always_comb begin
        base   = SHW'(PATTERN_MAX - int'(i_plen));
        stg[0] = i_pat;
        for (int s = 0; s < SHW; s++) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (!base[s]) begin
                    stg[s+1][i] = stg[s][i];
                end else if (i >= (1 << s)) begin
                    stg[s+1][i] = stg[s][i - (1 << s)];
                end else begin
                    stg[s+1][i] = '0;
                end
            end
        end
        o_align = stg[SHW];
        for (int i = 0; i < PATTERN_MAX; i++) begin
            o_care[i] = (i >= int'(base));
        end
    end

endmodule

// File: src/fixed_pattern_substring_search.sv
// Fixed-pattern substring search.
// Input channel (i_in_valid / o_in_stall / i_in_req): a request either loads
// one pattern byte (mode load, at pattern_index) or streams one text byte
// (mode text); last marks the final text byte of a buffer. A request is taken
// on a rising edge with valid high and stall low.
// Output channel (o_out_valid / i_out_stall / o_out_res): exactly one result
// per buffer, for the request with last set: found, match start/end offsets
// and the overflow flag. The result is registered: it appears in the cycle after
// the last text byte is taken.
// Throughput: one request per cycle while o_in_stall is low. The window shift,
// the parallel compare across the cell chain and the match bookkeeping all
// close in the cycle the text byte is taken; only the output register follows.
// When the output register is full and the receiver stalls, o_in_stall rises
// and holds off further requests until the result is taken.
// APB: pattern_length at 0x0, direction at 0x4; write anytime the block is idle.
// Reset (i_rst_n low, synchronous) clears both registers, the per-buffer
// state and the output valid flag; the pattern store keeps whatever it held
// and must be loaded before use.
module fixed_pattern_substring_search #(
    parameter int PATTERN_MAX = fpss_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = fpss_pkg::TEXT_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fpss_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fpss_pkg::t_res o_out_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import fpss_pkg::*;

    localparam int POS_W = $clog2(TEXT_MAX + 1);

    // ---------------- configuration registers ----------------
    logic [PLEN_W-1:0] r_plen;
    logic              r_dir;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_dir  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_PATTERN_LENGTH: r_plen <= pwdata[PLEN_W-1:0];
                REG_DIRECTION:      r_dir  <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PATTERN_LENGTH: prdata = {{(32-PLEN_W){1'b0}}, r_plen};
            REG_DIRECTION:      prdata = {31'b0, r_dir};
            default:            prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic in_acc;
    logic is_text;

    // hold off input only while a finished result is stuck
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_text     = (i_in_req.mode == MODE_TEXT);

    // ---------------- per-buffer state ----------------
    logic [POS_W-1:0] r_pos;
    logic             r_seen;
    logic [POS_W-1:0] r_best;
    logic             r_ovf;

    logic             shift_ok;
    logic [POS_W-1:0] pos_next;

    assign shift_ok = (int'(r_pos) < TEXT_MAX);
    assign pos_next = r_pos + POS_W'(1);

    // ---------------- cell chain ----------------
    t_cell_ctl                          cell_ctl;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] win;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] align_pat;
    logic [PATTERN_MAX-1:0]             care;
    logic [PATTERN_MAX-1:0]             hit;
    logic [PATTERN_MAX-1:0]             load;
    logic                               plen_ok;

    assign cell_ctl.shift = in_acc && is_text && shift_ok;
    assign cell_ctl.data  = i_in_req.data_byte;

    // pattern loads beyond the store depth drop out here
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            load[i] = in_acc && !is_text && (int'(i_in_req.pattern_index) == i);
        end
    end

    fpss_align #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_align (
        .i_pat     (pat),
        .i_plen    (r_plen),
        .o_align   (align_pat),
        .o_care    (care),
        .o_plen_ok (plen_ok)
    );

    // newest byte enters the top cell, oldest sits in cell 0
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        logic [BYTE_W-1:0] shift_in;
        if (g == PATTERN_MAX - 1) begin : g_top
            assign shift_in = i_in_req.data_byte;
        end else begin : g_mid
            assign shift_in = win[g+1];
        end

        fpss_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_load       (load[g]),
            .i_shift_byte (shift_in),
            .i_align_pat  (align_pat[g]),
            .i_care       (care[g]),
            .o_win        (win[g]),
            .o_pat        (pat[g]),
            .o_hit        (hit[g])
        );
    end

    // ---------------- match bookkeeping ----------------
    logic             match;
    logic             n_seen;
    logic [POS_W-1:0] n_best;
    logic             n_ovf;
    logic [POS_W-1:0] n_pos;
    t_res             n_res;

    always_comb begin
        // only windows fully inside this buffer's text can match
        match  = shift_ok && plen_ok && (int'(pos_next) >= int'(r_plen)) && (&hit);
        n_seen = r_seen || match;
        n_best = r_best;
        if (match && (r_dir || !r_seen)) begin
            n_best = POS_W'(int'(pos_next) - int'(r_plen));
        end
        n_ovf = r_ovf || !shift_ok;
        n_pos = shift_ok ? pos_next : r_pos;

        n_res.found    = n_seen && !n_ovf;
        n_res.overflow = n_ovf;
        if (n_res.found) begin
            n_res.match_start = START_W'(n_best);
            n_res.match_end   = END_W'(int'(n_best) + int'(r_plen));
        end else begin
            n_res.match_start = '0;
            n_res.match_end   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= 1'b0;
            r_best <= '0;
            r_ovf  <= 1'b0;
        end else if (in_acc && is_text) begin
            if (i_in_req.last) begin
                // buffer closes: back to the reset view
                r_pos  <= '0;
                r_seen <= 1'b0;
                r_best <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_seen <= n_seen;
                r_best <= n_best;
                r_ovf  <= n_ovf;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= in_acc && is_text && i_in_req.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_out_valid || !i_out_stall) && in_acc && is_text && i_in_req.last) begin
            o_out_res <= n_res;
        end
    end

endmodule
